// ----- design/mieu_pkg.sv -----
// ----------------------------------------------------------------------------
// mieu_pkg
// Types and instruction codes shared by the integer execute unit.
// ----------------------------------------------------------------------------
package mieu_pkg;

   localparam logic REQ_EXEC    = 1'b0;
   localparam logic REQ_PRELOAD = 1'b1;

   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_BLEZ    = 6'h06;
   localparam logic [5:0] OP_BGTZ    = 6'h07;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_SLTIU   = 6'h0B;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_XORI    = 6'h0E;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_LB      = 6'h20;
   localparam logic [5:0] OP_LH      = 6'h21;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_LBU     = 6'h24;
   localparam logic [5:0] OP_LHU     = 6'h25;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SH      = 6'h29;
   localparam logic [5:0] OP_SW      = 6'h2B;

   localparam logic [5:0] FN_SLL     = 6'h00;
   localparam logic [5:0] FN_SRL     = 6'h02;
   localparam logic [5:0] FN_SRA     = 6'h03;
   localparam logic [5:0] FN_JR      = 6'h08;
   localparam logic [5:0] FN_JALR    = 6'h09;
   localparam logic [5:0] FN_SYSCALL = 6'h0C;
   localparam logic [5:0] FN_MFHI    = 6'h10;
   localparam logic [5:0] FN_MTHI    = 6'h11;
   localparam logic [5:0] FN_MFLO    = 6'h12;
   localparam logic [5:0] FN_MTLO    = 6'h13;
   localparam logic [5:0] FN_MULT    = 6'h18;
   localparam logic [5:0] FN_MULTU   = 6'h19;
   localparam logic [5:0] FN_DIV     = 6'h1A;
   localparam logic [5:0] FN_DIVU    = 6'h1B;
   localparam logic [5:0] FN_ADD     = 6'h20;
   localparam logic [5:0] FN_ADDU    = 6'h21;
   localparam logic [5:0] FN_SUB     = 6'h22;
   localparam logic [5:0] FN_SUBU    = 6'h23;
   localparam logic [5:0] FN_AND     = 6'h24;
   localparam logic [5:0] FN_OR      = 6'h25;
   localparam logic [5:0] FN_XOR     = 6'h26;
   localparam logic [5:0] FN_NOR     = 6'h27;
   localparam logic [5:0] FN_SLT     = 6'h2A;
   localparam logic [5:0] FN_SLTU    = 6'h2B;

   localparam logic [4:0] REG_V0 = 5'd2;
   localparam logic [4:0] REG_A0 = 5'd4;
   localparam logic [4:0] REG_A1 = 5'd5;
   localparam logic [4:0] REG_RA = 5'd31;

   typedef enum logic [2:0] {
      K_PRELOAD,
      K_SIMPLE,
      K_MULT,
      K_DIV,
      K_LOAD,
      K_STORE,
      K_SYSCALL,
      K_UNKNOWN
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] iw;
      logic [15:0] pre_addr;
      logic [7:0]  pre_byte;
   } entry_type;

   typedef struct packed {
      logic [15:0] next_pc;
      logic        reg_written;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        syscall_seen;
      logic [31:0] syscall_code;
      logic [31:0] syscall_arg_a;
      logic [31:0] syscall_arg_b;
      logic        status;
   } result_type;

endpackage

// ----- design/mieu_if.sv -----
// ----------------------------------------------------------------------------
// mieu_if
// Request, response and control register channels of the execute unit.
// ----------------------------------------------------------------------------
interface mieu_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] instruction_word;
   logic [15:0] preload_address;
   logic [7:0]  preload_byte;
   modport source (output valid, opcode, instruction_word, preload_address,
                   preload_byte, input ready);
   modport sink (input valid, opcode, instruction_word, preload_address,
                 preload_byte, output ready);
endinterface

interface mieu_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] next_pc;
   logic        reg_written;
   logic [4:0]  reg_index;
   logic [31:0] reg_value;
   logic        syscall_seen;
   logic [31:0] syscall_code;
   logic [31:0] syscall_arg_a;
   logic [31:0] syscall_arg_b;
   logic        status;
   modport source (output valid, next_pc, reg_written, reg_index, reg_value,
                   syscall_seen, syscall_code, syscall_arg_a, syscall_arg_b,
                   status, input ready);
   modport sink (input valid, next_pc, reg_written, reg_index, reg_value,
                 syscall_seen, syscall_code, syscall_arg_a, syscall_arg_b,
                 status, output ready);
endinterface

interface mieu_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ----- design/mieu_ram.sv -----
// ----------------------------------------------------------------------------
// mieu_ram
// Generic RAM, one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mieu_ram #(
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [(64'd1 << ADDR_W)];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/mieu_front.sv -----
// ----------------------------------------------------------------------------
// mieu_front
// Request intake: classifies each request and pushes it into the queue.
// ----------------------------------------------------------------------------
module mieu_front (
   mieu_req_if.sink             req_ch,
   output logic                 push_valid,
   input  logic                 push_ready,
   output mieu_pkg::entry_type  push_data
);
   import mieu_pkg::*;

   logic [5:0] op;
   logic [5:0] fn;
   kind_type   kind;

   assign op = req_ch.instruction_word[31:26];
   assign fn = req_ch.instruction_word[5:0];

   always_comb begin
      kind = K_UNKNOWN;
      if (req_ch.opcode == REQ_PRELOAD) begin
         kind = K_PRELOAD;
      end else if (op == OP_SPECIAL) begin
         case (fn)
            FN_SLL, FN_SRL, FN_SRA, FN_JR, FN_JALR, FN_MFHI, FN_MTHI, FN_MFLO,
            FN_MTLO, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR,
            FN_NOR, FN_SLT, FN_SLTU: kind = K_SIMPLE;
            FN_SYSCALL:              kind = K_SYSCALL;
            FN_MULT, FN_MULTU:       kind = K_MULT;
            FN_DIV, FN_DIVU:         kind = K_DIV;
            default:                 kind = K_UNKNOWN;
         endcase
      end else begin
         case (op)
            OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU,
            OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI: kind = K_SIMPLE;
            OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU:               kind = K_LOAD;
            OP_SB, OP_SH, OP_SW:                               kind = K_STORE;
            default:                                           kind = K_UNKNOWN;
         endcase
      end
   end

   assign push_valid         = req_ch.valid;
   assign req_ch.ready       = push_ready;
   assign push_data.kind     = kind;
   assign push_data.iw       = req_ch.instruction_word;
   assign push_data.pre_addr = req_ch.preload_address;
   assign push_data.pre_byte = req_ch.preload_byte;

endmodule

// ----- design/mieu_queue.sv -----
// ----------------------------------------------------------------------------
// mieu_queue
// Two-entry queue between request intake and execution.
// ----------------------------------------------------------------------------
module mieu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  mieu_pkg::entry_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output mieu_pkg::entry_type pop_data
);
   import mieu_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- design/mieu_back.sv -----
// ----------------------------------------------------------------------------
// mieu_back
// Execution sequencer: register file, HI/LO, data memory, divider, result.
// ----------------------------------------------------------------------------
module mieu_back #(
   parameter int ADDR_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cfg_valid,
   input  logic [15:0]          cfg_data,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  mieu_pkg::entry_type  pop_data,
   output logic                 res_valid,
   input  logic                 res_ready,
   output mieu_pkg::result_type res_data
);
   import mieu_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_EXEC  = 9'b000000010,
      S_MRD   = 9'b000000100,
      S_MWAIT = 9'b000001000,
      S_MWR   = 9'b000010000,
      S_DIV   = 9'b000100000,
      S_SYSA  = 9'b001000000,
      S_SYSB  = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type            state_ff, state_in;
   entry_type            cur_ff, cur_in;
   logic [15:0]          pc_ff, pc_in;
   logic [31:0]          hi_ff, hi_in, lo_ff, lo_in;
   logic [31:0]          valid_ff, valid_in;
   result_type           res_ff, res_in;
   logic [4:0]           ra_idx_ff, rb_idx_ff;
   logic [ADDR_BITS-1:0] ea_ff, ea_in;
   logic [2:0]           cnt_ff, cnt_in, len_ff, len_in;
   logic [31:0]          sdata_ff, sdata_in;
   logic [31:0]          dq_ff, dq_in, dr_ff, dr_in, dd_ff, dd_in;
   logic [4:0]           dcnt_ff, dcnt_in;
   logic                 dneg_q_ff, dneg_q_in, dneg_r_ff, dneg_r_in;

   logic [4:0]           ra_addr, rb_addr;
   logic [31:0]          ra_data, rb_data;
   logic                 rf_wen;
   logic [4:0]           rf_waddr;
   logic [31:0]          rf_wdata;
   logic                 dm_wen;
   logic [ADDR_BITS-1:0] dm_waddr, dm_raddr;
   logic [7:0]           dm_wdata, dm_rdata;

   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, sh;
   logic [15:0] imm;
   logic [31:0] simm, a, b, ea_full;
   logic [15:0] pc4, btarget;

   logic        s_wen, s_hi_wen, s_lo_wen;
   logic [4:0]  s_dst;
   logic [31:0] s_val;
   logic [15:0] s_pc;

   logic        m_sgn, d_sgn;
   logic [65:0] prod;
   logic [31:0] ma, mb;
   logic [32:0] shifted, trial;
   logic [31:0] rem_n, q_n;
   logic [31:0] acc, ld_val;

   assign op   = cur_ff.iw[31:26];
   assign rs   = cur_ff.iw[25:21];
   assign rt   = cur_ff.iw[20:16];
   assign rd   = cur_ff.iw[15:11];
   assign sh   = cur_ff.iw[10:6];
   assign fn   = cur_ff.iw[5:0];
   assign imm  = cur_ff.iw[15:0];
   assign simm = {{16{imm[15]}}, imm};

   assign a       = valid_ff[ra_idx_ff] ? ra_data : 32'd0;
   assign b       = valid_ff[rb_idx_ff] ? rb_data : 32'd0;
   assign ea_full = a + simm;
   assign pc4     = pc_ff + 16'd4;
   assign btarget = pc4 + {simm[13:0], 2'b00};

   mieu_ram #(.WIDTH(32), .ADDR_W(5)) u_rf_a (
      .clock(clock), .wr_en(rf_wen), .wr_addr(rf_waddr), .wr_data(rf_wdata),
      .rd_addr(ra_addr), .rd_data(ra_data)
   );

   mieu_ram #(.WIDTH(32), .ADDR_W(5)) u_rf_b (
      .clock(clock), .wr_en(rf_wen), .wr_addr(rf_waddr), .wr_data(rf_wdata),
      .rd_addr(rb_addr), .rd_data(rb_data)
   );

   mieu_ram #(.WIDTH(8), .ADDR_W(ADDR_BITS)) u_dmem (
      .clock(clock), .wr_en(dm_wen), .wr_addr(dm_waddr), .wr_data(dm_wdata),
      .rd_addr(dm_raddr), .rd_data(dm_rdata)
   );

   always_comb begin
      s_wen    = 1'b0;
      s_hi_wen = 1'b0;
      s_lo_wen = 1'b0;
      s_dst    = rd;
      s_val    = 32'd0;
      s_pc     = pc4;
      if (op == OP_SPECIAL) begin
         case (fn)
            FN_SLL:  begin s_wen = 1'b1; s_val = b << sh; end
            FN_SRL:  begin s_wen = 1'b1; s_val = b >> sh; end
            FN_SRA:  begin s_wen = 1'b1; s_val = 32'($signed(b) >>> sh); end
            FN_JR:   s_pc = a[15:0];
            FN_JALR: begin s_wen = 1'b1; s_val = {16'd0, pc4}; s_pc = a[15:0]; end
            FN_MFHI: begin s_wen = 1'b1; s_val = hi_ff; end
            FN_MTHI: s_hi_wen = 1'b1;
            FN_MFLO: begin s_wen = 1'b1; s_val = lo_ff; end
            FN_MTLO: s_lo_wen = 1'b1;
            FN_ADD, FN_ADDU: begin s_wen = 1'b1; s_val = a + b; end
            FN_SUB, FN_SUBU: begin s_wen = 1'b1; s_val = a - b; end
            FN_AND:  begin s_wen = 1'b1; s_val = a & b; end
            FN_OR:   begin s_wen = 1'b1; s_val = a | b; end
            FN_XOR:  begin s_wen = 1'b1; s_val = a ^ b; end
            FN_NOR:  begin s_wen = 1'b1; s_val = ~(a | b); end
            FN_SLT:  begin s_wen = 1'b1; s_val = {31'd0, $signed(a) < $signed(b)}; end
            FN_SLTU: begin s_wen = 1'b1; s_val = {31'd0, a < b}; end
            default: s_wen = 1'b0;
         endcase
      end else begin
         s_dst = rt;
         case (op)
            OP_J:   s_pc = imm;
            OP_JAL: begin
               s_wen = 1'b1; s_dst = REG_RA; s_val = {16'd0, pc4}; s_pc = imm;
            end
            OP_BEQ:  if (a == b) s_pc = btarget;
            OP_BNE:  if (a != b) s_pc = btarget;
            OP_BLEZ: if ((a == 32'd0) || a[31]) s_pc = btarget;
            OP_BGTZ: if ((a != 32'd0) && !a[31]) s_pc = btarget;
            OP_ADDI, OP_ADDIU: begin s_wen = 1'b1; s_val = a + simm; end
            OP_SLTI:  begin s_wen = 1'b1; s_val = {31'd0, $signed(a) < $signed(simm)}; end
            OP_SLTIU: begin s_wen = 1'b1; s_val = {31'd0, a < simm}; end
            OP_ANDI:  begin s_wen = 1'b1; s_val = a & {16'd0, imm}; end
            OP_ORI:   begin s_wen = 1'b1; s_val = a | {16'd0, imm}; end
            OP_XORI:  begin s_wen = 1'b1; s_val = a ^ {16'd0, imm}; end
            OP_LUI:   begin s_wen = 1'b1; s_val = {imm, 16'd0}; end
            default:  s_wen = 1'b0;
         endcase
      end
   end

   always_comb begin
      m_sgn   = (fn == FN_MULT);
      d_sgn   = (fn == FN_DIV);
      prod    = 66'($signed({m_sgn & a[31], a}) * $signed({m_sgn & b[31], b}));
      ma      = (d_sgn && a[31]) ? (32'd0 - a) : a;
      mb      = (d_sgn && b[31]) ? (32'd0 - b) : b;
      shifted = {dr_ff, dq_ff[31]};
      trial   = shifted - {1'b0, dd_ff};
      if (!trial[32]) begin
         rem_n = trial[31:0];
         q_n   = {dq_ff[30:0], 1'b1};
      end else begin
         rem_n = shifted[31:0];
         q_n   = {dq_ff[30:0], 1'b0};
      end
      acc = {sdata_ff[23:0], dm_rdata};
      case (op)
         OP_LB:   ld_val = {{24{acc[7]}}, acc[7:0]};
         OP_LBU:  ld_val = {24'd0, acc[7:0]};
         OP_LH:   ld_val = {{16{acc[15]}}, acc[15:0]};
         OP_LHU:  ld_val = {16'd0, acc[15:0]};
         default: ld_val = acc;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      pc_in     = pc_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      valid_in  = valid_ff;
      res_in    = res_ff;
      ea_in     = ea_ff;
      cnt_in    = cnt_ff;
      len_in    = len_ff;
      sdata_in  = sdata_ff;
      dq_in     = dq_ff;
      dr_in     = dr_ff;
      dd_in     = dd_ff;
      dcnt_in   = dcnt_ff;
      dneg_q_in = dneg_q_ff;
      dneg_r_in = dneg_r_ff;
      ra_addr   = pop_data.iw[25:21];
      rb_addr   = pop_data.iw[20:16];
      rf_wen    = 1'b0;
      rf_waddr  = s_dst;
      rf_wdata  = s_val;
      dm_wen    = 1'b0;
      dm_waddr  = ea_ff + ADDR_BITS'(cnt_ff);
      dm_wdata  = sdata_ff[31:24];
      dm_raddr  = ea_ff + ADDR_BITS'(cnt_ff);
      pop_ready = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               cur_in   = pop_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_in         = '0;
            res_in.next_pc = pc4;
            pc_in          = pc4;
            state_in       = S_OUT;
            case (cur_ff.kind)
               K_PRELOAD: begin
                  dm_wen         = 1'b1;
                  dm_waddr       = ADDR_BITS'(cur_ff.pre_addr);
                  dm_wdata       = cur_ff.pre_byte;
                  pc_in          = pc_ff;
                  res_in.next_pc = pc_ff;
               end
               K_SIMPLE: begin
                  pc_in          = s_pc;
                  res_in.next_pc = s_pc;
                  if (s_hi_wen) hi_in = a;
                  if (s_lo_wen) lo_in = a;
                  if (s_wen && (s_dst != 5'd0)) begin
                     rf_wen              = 1'b1;
                     valid_in[s_dst]     = 1'b1;
                     res_in.reg_written  = 1'b1;
                     res_in.reg_index    = s_dst;
                     res_in.reg_value    = s_val;
                  end
               end
               K_MULT: begin
                  hi_in = prod[63:32];
                  lo_in = prod[31:0];
               end
               K_DIV: begin
                  if (b == 32'd0) begin
                     lo_in = '1;
                     hi_in = a;
                  end else begin
                     dq_in     = ma;
                     dr_in     = 32'd0;
                     dd_in     = mb;
                     dcnt_in   = 5'd0;
                     dneg_q_in = d_sgn && (a[31] ^ b[31]);
                     dneg_r_in = d_sgn && a[31];
                     state_in  = S_DIV;
                  end
               end
               K_LOAD, K_STORE: begin
                  ea_in  = ea_full[ADDR_BITS-1:0];
                  cnt_in = 3'd0;
                  case (op)
                     OP_LB, OP_LBU, OP_SB: len_in = 3'd1;
                     OP_LH, OP_LHU, OP_SH: len_in = 3'd2;
                     default:              len_in = 3'd4;
                  endcase
                  case (op)
                     OP_SB:   sdata_in = {b[7:0], 24'd0};
                     OP_SH:   sdata_in = {b[15:0], 16'd0};
                     OP_SW:   sdata_in = b;
                     default: sdata_in = 32'd0;
                  endcase
                  state_in = (cur_ff.kind == K_LOAD) ? S_MRD : S_MWR;
               end
               K_SYSCALL: begin
                  ra_addr  = REG_V0;
                  rb_addr  = REG_A0;
                  state_in = S_SYSA;
               end
               K_UNKNOWN: res_in.status = 1'b1;
               default:   res_in.status = 1'b1;
            endcase
         end
         S_MRD: state_in = S_MWAIT;
         S_MWAIT: begin
            sdata_in = acc;
            cnt_in   = cnt_ff + 3'd1;
            state_in = S_MRD;
            if (cnt_ff == len_ff - 3'd1) begin
               state_in = S_OUT;
               if (rt != 5'd0) begin
                  rf_wen             = 1'b1;
                  rf_waddr           = rt;
                  rf_wdata           = ld_val;
                  valid_in[rt]       = 1'b1;
                  res_in.reg_written = 1'b1;
                  res_in.reg_index   = rt;
                  res_in.reg_value   = ld_val;
               end
            end
         end
         S_MWR: begin
            dm_wen   = 1'b1;
            sdata_in = {sdata_ff[23:0], 8'd0};
            cnt_in   = cnt_ff + 3'd1;
            if (cnt_ff == len_ff - 3'd1) state_in = S_OUT;
         end
         S_DIV: begin
            dq_in   = q_n;
            dr_in   = rem_n;
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'd31) begin
               lo_in    = dneg_q_ff ? (32'd0 - q_n) : q_n;
               hi_in    = dneg_r_ff ? (32'd0 - rem_n) : rem_n;
               state_in = S_OUT;
            end
         end
         S_SYSA: begin
            res_in.syscall_seen  = 1'b1;
            res_in.syscall_code  = a;
            res_in.syscall_arg_a = b;
            ra_addr              = REG_A1;
            state_in             = S_SYSB;
         end
         S_SYSB: begin
            res_in.syscall_arg_b = a;
            state_in             = S_OUT;
         end
         S_OUT: if (res_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase

      if (cfg_valid) pc_in = cfg_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff    <= 16'd0;
         hi_ff    <= 32'd0;
         lo_ff    <= 32'd0;
         valid_ff <= 32'd0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
         valid_ff <= valid_in;
      end
      cur_ff    <= cur_in;
      res_ff    <= res_in;
      ra_idx_ff <= ra_addr;
      rb_idx_ff <= rb_addr;
      ea_ff     <= ea_in;
      cnt_ff    <= cnt_in;
      len_ff    <= len_in;
      sdata_ff  <= sdata_in;
      dq_ff     <= dq_in;
      dr_ff     <= dr_in;
      dd_ff     <= dd_in;
      dcnt_ff   <= dcnt_in;
      dneg_q_ff <= dneg_q_in;
      dneg_r_ff <= dneg_r_in;
   end

   assign res_valid = (state_ff == S_OUT);
   assign res_data  = res_ff;

endmodule

// ----- design/mips_integer_execute_unit_top.sv -----
// ----------------------------------------------------------------------------
// mips_integer_execute_unit_top
// MIPS-I integer execute unit: request intake, queue and execution sequencer.
//
//   channel   direction  payload
//   req_ch    in         opcode, instruction_word, preload_address, preload_byte
//   rsp_ch    out        next_pc, register write, syscall report, status
//   csr_ch    in         start_pc (also reloads the program counter)
//
// A request passes through the sequencer as a register file RAM read, execute
// and response; loads and stores access data memory one byte at a time,
// syscalls read the register file twice and divides use a radix-2 divider
// (skipped for a zero divisor); multiplies finish in the execute cycle.
// The register file reads zero after reset through per-entry valid bits; the
// data memory is not cleared. Intake keeps accepting into a two-entry queue
// while a response waits on rsp_ch.
// ----------------------------------------------------------------------------
module mips_integer_execute_unit_top #(
   parameter int ADDR_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   mieu_req_if.sink    req_ch,
   mieu_rsp_if.source  rsp_ch,
   mieu_csr_if.sink    csr_ch
);
   import mieu_pkg::*;

   logic       push_valid, push_ready, pop_valid, pop_ready;
   entry_type  push_data, pop_data;
   result_type res;

   assign csr_ch.ready = 1'b1;

   mieu_front u_front (
      .req_ch(req_ch), .push_valid(push_valid), .push_ready(push_ready),
      .push_data(push_data)
   );

   mieu_queue u_queue (
      .clock(clock), .reset(reset),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
   );

   mieu_back #(.ADDR_BITS(ADDR_BITS)) u_back (
      .clock(clock), .reset(reset),
      .cfg_valid(csr_ch.valid), .cfg_data(csr_ch.data),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
      .res_valid(rsp_ch.valid), .res_ready(rsp_ch.ready), .res_data(res)
   );

   assign rsp_ch.next_pc       = res.next_pc;
   assign rsp_ch.reg_written   = res.reg_written;
   assign rsp_ch.reg_index     = res.reg_index;
   assign rsp_ch.reg_value     = res.reg_value;
   assign rsp_ch.syscall_seen  = res.syscall_seen;
   assign rsp_ch.syscall_code  = res.syscall_code;
   assign rsp_ch.syscall_arg_a = res.syscall_arg_a;
   assign rsp_ch.syscall_arg_b = res.syscall_arg_b;
   assign rsp_ch.status        = res.status;

endmodule

// ----- design/mieu_checker.sv -----
// ----------------------------------------------------------------------------
// mieu_checker
// Port-level checks on the execute unit response channel.
// ----------------------------------------------------------------------------
module mieu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] next_pc,
   input logic        reg_written,
   input logic [4:0]  reg_index,
   input logic [31:0] reg_value,
   input logic        syscall_seen,
   input logic        status
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(next_pc) && $stable(reg_value))
      else $error("response changed while stalled");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_nowrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !reg_written |-> reg_index == 5'd0 && reg_value == 32'd0)
      else $error("register fields set without a write");

   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (syscall_seen || status) |-> !reg_written)
      else $error("register write on syscall or unknown request");

   a_unk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status |-> !syscall_seen)
      else $error("unknown request reported as syscall");

endmodule

bind mips_integer_execute_unit_top mieu_checker u_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
   .next_pc(rsp_ch.next_pc), .reg_written(rsp_ch.reg_written),
   .reg_index(rsp_ch.reg_index), .reg_value(rsp_ch.reg_value),
   .syscall_seen(rsp_ch.syscall_seen), .status(rsp_ch.status)
);
